>>> design/assert_macros.svh
// assertion macros used by the scheduler engine (dbfs_engine)
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

>>> design/dbfs_pkg.sv
`timescale 1ns / 1ps
// types and constants of the double buffer frame scheduler
// used by every module of the block, depends on nothing
package dbfs_pkg;

  localparam logic [15:0] MAX_FRAME_BYTES = 16'd512;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 168;

  // sticky status bit positions
  localparam int BIT_SWEEP_LATE = 0;
  localparam int BIT_TICK_LATE  = 1;
  localparam int BIT_TX_BUSY    = 2;
  localparam int BIT_TX_ERROR   = 3;

  typedef enum logic [3:0] {
    EV_CLAIM       = 4'd0,
    EV_PUBLISH     = 4'd1,
    EV_TICK        = 4'd2,
    EV_TX_STARTED  = 4'd3,
    EV_START_FAIL  = 4'd4,
    EV_TX_DONE     = 4'd5,
    EV_TX_ERROR    = 4'd6,
    EV_RECOV_BEGIN = 4'd7,
    EV_RECOV_DONE  = 4'd8
  } event_t;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_BUILDING = 2'd1,
    ST_READY    = 2'd2,
    ST_SENDING  = 2'd3
  } slot_st_t;

  typedef struct packed {
    event_t      mode;
    logic [1:0]  buffer_slot;
    logic [15:0] frame_length;
    logic [31:0] tick_periods;
    logic        tx_enable;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic        granted_slot;
    logic [31:0] granted_sequence;
    logic [3:0]  status_bits;
    logic [31:0] overrun_count;
    logic [31:0] error_count;
    logic [31:0] missed_count;
    logic [31:0] sent_count;
    logic        sending_valid;
    logic        sending_slot;
  } result_t;

endpackage

>>> design/double_buffer_frame_scheduler_core.sv
`timescale 1ns / 1ps
// top level of the double buffer frame scheduler
// depends on dbfs_pkg, dbfs_in_reg, dbfs_engine and dbfs_out_reg
//
//  channel | ports                          | carries
//  --------+--------------------------------+--------------------------------
//  in      | in_tvalid in_tready in_tdata   | one event item, kind in tuser
//          | in_tuser                       |
//  out     | out_tvalid out_tready out_tdata| one result item per event
//
// one item per cycle sustained while out_tready is high; each item passes
// the input register, then event logic into the result register (out_tvalid)
// synchronous active-low reset clears both valid flags and the scheduler state
// a stalled output holds its item while one more item waits in the input register
module double_buffer_frame_scheduler_core import dbfs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] buffer_slot, [17:2] frame_length, [49:18] tick_periods,
  // [50] tx_enable, [55:51] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [3:0] mode
  input  logic [3:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] ok, [1] granted_slot, [33:2] granted_sequence, [37:34] status_bits,
  // [69:38] overrun_count, [101:70] error_count, [133:102] missed_count,
  // [165:134] sent_count, [166] sending_valid, [167] sending_slot
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic    item_valid;
  logic    result_space;
  item_t   item;
  result_t result;
  logic    advance;

  assign advance = item_valid && result_space;

  dbfs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dbfs_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  dbfs_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .space      (result_space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> design/dbfs_in_reg.sv
`timescale 1ns / 1ps
// input register of the scheduler: unpacks the stream and holds one item
// depends on dbfs_pkg
module dbfs_in_reg import dbfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [3:0]            in_tuser,
  input  logic                  advance,
  output logic                  item_valid,
  output item_t                 item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.mode         <= event_t'(in_tuser);
      item_r.buffer_slot  <= in_tdata[1:0];
      item_r.frame_length <= in_tdata[17:2];
      item_r.tick_periods <= in_tdata[49:18];
      item_r.tx_enable    <= in_tdata[50];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> design/dbfs_engine.sv
`timescale 1ns / 1ps
// scheduler state and the single-pass event logic
// depends on dbfs_pkg and assert_macros.svh
`include "assert_macros.svh"
module dbfs_engine import dbfs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  output result_t result
);

  slot_st_t    slot_state_r [2];
  slot_st_t    slot_state_nxt [2];
  logic [31:0] slot_seq_r [2];
  logic [31:0] slot_seq_nxt [2];
  logic [31:0] cur_period_r, cur_period_nxt;
  logic [31:0] req_period_r, req_period_nxt;
  logic        act_valid_r, act_valid_nxt;
  logic        act_idx_r, act_idx_nxt;
  logic        recov_pend_r, recov_pend_nxt;
  logic        recovering_r, recovering_nxt;
  logic        start_conf_r, start_conf_nxt;
  logic [3:0]  sticky_r, sticky_nxt;
  logic [31:0] overruns_r, overruns_nxt;
  logic [31:0] errors_r, errors_nxt;
  logic [31:0] missed_r, missed_nxt;
  logic [31:0] sent_r, sent_nxt;

  logic        dup;
  logic        pub_slot;
  logic        pub_bad;
  logic [31:0] cur_sum;
  logic [1:0]  fresh;
  logic        have_ready;
  logic        ready_idx;
  logic [31:0] act_dist;
  logic        recov_tick;
  logic        go;

  // claim is refused if the requested period already owns a live buffer
  always_comb begin
    dup = 1'b0;
    for (int s = 0; s < 2; s++) begin
      if ((slot_state_r[s] == ST_BUILDING || slot_state_r[s] == ST_READY) &&
          slot_seq_r[s] == req_period_r) begin
        dup = 1'b1;
      end
    end
  end

  assign pub_slot = item.buffer_slot[0];
  assign pub_bad  = (slot_seq_r[pub_slot] != req_period_r) ||
                    (item.frame_length == 16'd0) ||
                    (item.frame_length > MAX_FRAME_BYTES);

  assign cur_sum = cur_period_r + item.tick_periods;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      fresh[s] = (slot_state_r[s] == ST_READY) && (slot_seq_r[s] == cur_sum);
    end
  end

  assign have_ready = fresh[0] || fresh[1];
  // the higher slot wins when both are fresh
  assign ready_idx  = fresh[1];
  assign act_dist   = cur_sum - slot_seq_r[act_idx_r];
  assign recov_tick = recov_pend_r || (act_valid_r && (act_dist >= 32'd2));
  assign go = !act_valid_r && !recov_tick && !recovering_r && item.tx_enable &&
              have_ready;

  always_comb begin
    slot_state_nxt = slot_state_r;
    slot_seq_nxt   = slot_seq_r;
    cur_period_nxt = cur_period_r;
    req_period_nxt = req_period_r;
    act_valid_nxt  = act_valid_r;
    act_idx_nxt    = act_idx_r;
    recov_pend_nxt = recov_pend_r;
    recovering_nxt = recovering_r;
    start_conf_nxt = start_conf_r;
    sticky_nxt     = sticky_r;
    overruns_nxt   = overruns_r;
    errors_nxt     = errors_r;
    missed_nxt     = missed_r;
    sent_nxt       = sent_r;
    result         = '0;

    unique case (item.mode)
      EV_CLAIM: begin
        if (!recov_pend_r && !recovering_r && !dup) begin
          if (slot_state_r[0] == ST_FREE) begin
            slot_seq_nxt[0]         = req_period_r;
            slot_state_nxt[0]       = ST_BUILDING;
            result.ok               = 1'b1;
            result.granted_sequence = req_period_r;
          end else if (slot_state_r[1] == ST_FREE) begin
            slot_seq_nxt[1]         = req_period_r;
            slot_state_nxt[1]       = ST_BUILDING;
            result.ok               = 1'b1;
            result.granted_slot     = 1'b1;
            result.granted_sequence = req_period_r;
          end
        end
      end
      EV_PUBLISH: begin
        if (!item.buffer_slot[1] && slot_state_r[pub_slot] == ST_BUILDING) begin
          if (pub_bad) begin
            slot_state_nxt[pub_slot]   = ST_FREE;
            overruns_nxt               = overruns_r + 32'd1;
            sticky_nxt[BIT_SWEEP_LATE] = 1'b1;
          end else begin
            slot_state_nxt[pub_slot] = ST_READY;
            result.ok                = 1'b1;
          end
        end
      end
      EV_TICK: begin
        if (item.tick_periods != 32'd0) begin
          cur_period_nxt = cur_sum;
          req_period_nxt = cur_sum + 32'd1;
          if (item.tick_periods > 32'd1 || !item.tx_enable) begin
            sticky_nxt[BIT_TICK_LATE] = 1'b1;
          end
          // stale ready buffers are dropped
          for (int s = 0; s < 2; s++) begin
            if (slot_state_r[s] == ST_READY && !fresh[s]) begin
              slot_state_nxt[s] = ST_FREE;
            end
          end
          if (act_valid_r) begin
            sticky_nxt[BIT_TX_BUSY] = 1'b1;
          end
          recov_pend_nxt = recov_tick;
          missed_nxt = missed_r + item.tick_periods - {31'd0, go};
          if (go) begin
            slot_state_nxt[ready_idx] = ST_SENDING;
            act_valid_nxt             = 1'b1;
            act_idx_nxt               = ready_idx;
            start_conf_nxt            = 1'b0;
            result.ok                 = 1'b1;
            result.granted_slot       = ready_idx;
          end else begin
            if (have_ready) begin
              slot_state_nxt[ready_idx] = ST_FREE;
            end
            if (!have_ready && !act_valid_r && !recov_tick && item.tx_enable) begin
              sticky_nxt[BIT_SWEEP_LATE] = 1'b1;
            end
          end
        end
      end
      EV_TX_STARTED: begin
        if (act_valid_r) begin
          start_conf_nxt = 1'b1;
        end
      end
      EV_START_FAIL: begin
        errors_nxt               = errors_r + 32'd1;
        missed_nxt               = missed_r + 32'd1;
        sticky_nxt[BIT_TX_ERROR] = 1'b1;
        recov_pend_nxt           = 1'b1;
      end
      EV_TX_DONE: begin
        if (act_valid_r) begin
          slot_state_nxt[act_idx_r] = ST_FREE;
          act_valid_nxt             = 1'b0;
          if (start_conf_r) begin
            sent_nxt = sent_r + 32'd1;
          end
          start_conf_nxt = 1'b0;
        end
      end
      EV_TX_ERROR: begin
        errors_nxt               = errors_r + 32'd1;
        sticky_nxt[BIT_TX_ERROR] = 1'b1;
        recov_pend_nxt           = 1'b1;
      end
      EV_RECOV_BEGIN: begin
        recovering_nxt = 1'b1;
      end
      EV_RECOV_DONE: begin
        if (act_valid_r) begin
          slot_state_nxt[act_idx_r] = ST_FREE;
        end
        act_valid_nxt  = 1'b0;
        recov_pend_nxt = 1'b0;
        recovering_nxt = 1'b0;
        start_conf_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    result.status_bits   = sticky_nxt;
    result.overrun_count = overruns_nxt;
    result.error_count   = errors_nxt;
    result.missed_count  = missed_nxt;
    result.sent_count    = sent_nxt;
    result.sending_valid = act_valid_nxt;
    result.sending_slot  = act_valid_nxt && act_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_state_r[0] <= ST_FREE;
      slot_state_r[1] <= ST_FREE;
      slot_seq_r[0]   <= 32'd0;
      slot_seq_r[1]   <= 32'd0;
      cur_period_r    <= 32'd0;
      req_period_r    <= 32'd1;
      act_valid_r     <= 1'b0;
      act_idx_r       <= 1'b0;
      recov_pend_r    <= 1'b0;
      recovering_r    <= 1'b0;
      start_conf_r    <= 1'b0;
      sticky_r        <= 4'd0;
      overruns_r      <= 32'd0;
      errors_r        <= 32'd0;
      missed_r        <= 32'd0;
      sent_r          <= 32'd0;
    end else if (advance) begin
      slot_state_r <= slot_state_nxt;
      slot_seq_r   <= slot_seq_nxt;
      cur_period_r <= cur_period_nxt;
      req_period_r <= req_period_nxt;
      act_valid_r  <= act_valid_nxt;
      act_idx_r    <= act_idx_nxt;
      recov_pend_r <= recov_pend_nxt;
      recovering_r <= recovering_nxt;
      start_conf_r <= start_conf_nxt;
      sticky_r     <= sticky_nxt;
      overruns_r   <= overruns_nxt;
      errors_r     <= errors_nxt;
      missed_r     <= missed_nxt;
      sent_r       <= sent_nxt;
    end
  end

  // the transmitter owns exactly the active slot
  `ASSERT_IMPL(a_active_sending, act_valid_r, slot_state_r[act_idx_r] == ST_SENDING, "active slot not sending")
  `ASSERT_IMPL(a_idle_no_sending, !act_valid_r, slot_state_r[0] != ST_SENDING && slot_state_r[1] != ST_SENDING, "slot sending without owner")
  `ASSERT_ALWAYS(a_period_link, req_period_r == cur_period_r + 32'd1, "requested period out of step")

endmodule

>>> design/dbfs_out_reg.sv
`timescale 1ns / 1ps
// result register of the scheduler: holds one packed result until taken
// depends on dbfs_pkg
module dbfs_out_reg import dbfs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  result_t                result,
  output logic                   space,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   valid_r;
  logic                   valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;

  assign space = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {result.sending_slot, result.sending_valid, result.sent_count,
                 result.missed_count, result.error_count, result.overrun_count,
                 result.status_bits, result.granted_sequence, result.granted_slot,
                 result.ok};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule
